// File: hdl/crls_pkg.sv
// Shared types, widths and arithmetic helpers for the linear system solver.
// No dependencies; every other file but crls_ram imports this package.
package crls_pkg;

   localparam int MAX_VARS_DEF = 8;

   localparam int ROW_W  = 3;
   localparam int COL_W  = 4;
   localparam int VAL_W  = 32;
   localparam int DET_W  = 64;
   localparam int SLOT_W = 3;
   localparam int STAT_W = 2;
   localparam int CFG_W  = 4;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [CSR_AW-1:0] CSR_VAR_COUNT = 3'd0;
   localparam logic [CFG_W-1:0]  VAR_COUNT_RST = 4'd2;

   localparam logic [STAT_W-1:0] STAT_UNIQUE   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_INFINITE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NONE     = 2'd2;

   localparam logic [DET_W-1:0] DET_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [DET_W-1:0] DET_MIN = 64'h8000_0000_0000_0000;
   localparam logic [DET_W-1:0] DET_ONE = 64'h0000_0001_0000_0000;

   // source of the work matrix write data
   typedef enum logic [2:0] {
      WSRC_COEF,
      WSRC_A,
      WSRC_B,
      WSRC_SUB,
      WSRC_ZERO
   } wsrc_type;

   typedef struct packed {
      logic     w_we;
      wsrc_type w_src;
      logic     ld_a;
      logic     ld_b;
      logic     div_start;
      logic     div_sol;
      logic     mul_start;
      logic     mul_prod;
      logic     ratio_ld;
      logic     prod_init;
      logic     prod_ld;
      logic     flip_tgl;
      logic     flip_clr;
      logic     det_wr;
      logic     out_ld;
      logic     out_status;
      logic     out_final;
      logic     coef_clr;
   } cmd_type;

   typedef struct packed {
      logic a_zero;
      logic b_zero;
      logic div_done;
      logic mul_done;
      logic d0_zero;
      logic any_nz;
   } stat_type;

   function automatic logic [DET_W-1:0] mag64(input logic [DET_W-1:0] v);
      return v[DET_W-1] ? (~v + 64'd1) : v;
   endfunction

   function automatic logic [DET_W-1:0] from_mag64(input logic [DET_W-1:0] m,
                                                   input logic neg, input logic ovf);
      logic [DET_W-1:0] r;
      if (neg) begin
         r = (ovf || m[DET_W-1]) ? DET_MIN : (~m + 64'd1);
      end else begin
         r = (ovf || m[DET_W-1]) ? DET_MAX : m;
      end
      return r;
   endfunction

   function automatic logic [DET_W-1:0] sat_sub64(input logic [DET_W-1:0] a,
                                                  input logic [DET_W-1:0] b);
      logic [DET_W:0] d;
      logic [DET_W-1:0] r;
      d = {a[DET_W-1], a} - {b[DET_W-1], b};
      if (d[DET_W] != d[DET_W-1]) begin
         r = d[DET_W] ? DET_MIN : DET_MAX;
      end else begin
         r = d[DET_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [DET_W-1:0] neg_sat64(input logic [DET_W-1:0] v);
      return (v == DET_MIN) ? DET_MAX : (~v + 64'd1);
   endfunction

endpackage

// File: hdl/crls_if.sv
// Valid/ready channel interfaces for entry words and result words.
// Depends on crls_pkg.
interface crls_req_if;
   import crls_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ROW_W-1:0]        row_index;
   logic [COL_W-1:0]        col_index;
   logic signed [VAL_W-1:0] entry_value;
   logic                    last_entry;

   modport source (output valid, row_index, col_index, entry_value, last_entry,
                   input ready);
   modport sink (input valid, row_index, col_index, entry_value, last_entry,
                 output ready);
endinterface

interface crls_rsp_if;
   import crls_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [SLOT_W-1:0]       var_slot;
   logic signed [VAL_W-1:0] solution_value;
   logic [STAT_W-1:0]       solve_status;
   logic                    final_result;

   modport source (output valid, var_slot, solution_value, solve_status, final_result,
                   input ready);
   modport sink (input valid, var_slot, solution_value, solve_status, final_result,
                 output ready);
endinterface

// File: hdl/crls_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module crls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule

// File: hdl/crls_div.sv
// Radix-2 restoring divider: floor((|num| << sh) / |den|), one bit per cycle,
// with Q32.32 or Q16.16 saturation on the result. Depends on crls_pkg.
module crls_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       sol_mode,
   input  logic [crls_pkg::DET_W-1:0] num,
   input  logic [crls_pkg::DET_W-1:0] den,
   output logic                       done_ff,
   output logic [crls_pkg::DET_W-1:0] result
);
   import crls_pkg::*;

   logic [DET_W-1:0] rem_ff, lo_ff, q_ff, den_ff;
   logic [6:0]       cnt_ff;
   logic             busy_ff, ovf_ff, neg_ff, mode_ff;
   logic [DET_W-1:0] ua, ub, rem_init;
   logic [DET_W:0]   rem2;
   logic [DET_W-1:0] qs;
   logic [DET_W-1:0] limit;

   assign ua       = mag64(num);
   assign ub       = mag64(den);
   assign rem_init = sol_mode ? (ua >> 48) : (ua >> 32);
   assign rem2     = {rem_ff, lo_ff[DET_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mode_ff <= sol_mode;
            neg_ff  <= num[DET_W-1] ^ den[DET_W-1];
            den_ff  <= ub;
            rem_ff  <= rem_init;
            lo_ff   <= sol_mode ? (ua << 16) : (ua << 32);
            q_ff    <= '0;
            cnt_ff  <= '0;
            if (ub == '0) begin
               ovf_ff  <= (ua != '0);
               done_ff <= 1'b1;
            end else if (rem_init >= ub) begin
               ovf_ff  <= 1'b1;
               done_ff <= 1'b1;
            end else begin
               ovf_ff  <= 1'b0;
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            lo_ff <= lo_ff << 1;
            if (rem2 >= {1'b0, den_ff}) begin
               rem_ff <= DET_W'(rem2 - {1'b0, den_ff});
               q_ff   <= {q_ff[DET_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem2[DET_W-1:0];
               q_ff   <= {q_ff[DET_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Q16.16 solution clamps to the 32-bit range before the sign goes back on
   assign limit = neg_ff ? 64'h8000_0000 : 64'h7FFF_FFFF;
   assign qs    = (ovf_ff || (q_ff > limit)) ? limit : q_ff;

   always_comb begin
      if (mode_ff) begin
         result = {32'b0, (neg_ff ? (~qs[31:0] + 32'd1) : qs[31:0])};
      end else begin
         result = from_mag64(q_ff, neg_ff, ovf_ff);
      end
   end
endmodule

// File: hdl/crls_dp.sv
// Datapath: entry store, work matrix, pivot registers, multiplier, divider,
// determinant registers and result word register. Depends on crls_pkg, crls_ram, crls_div.
module crls_dp #(
   parameter int MAX_VARS = crls_pkg::MAX_VARS_DEF,
   parameter int CW       = $clog2(MAX_VARS + 1),
   parameter int IW       = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1,
   parameter int WAW      = (MAX_VARS * MAX_VARS > 1) ? $clog2(MAX_VARS * MAX_VARS) : 1,
   parameter int CAW      = $clog2(MAX_VARS * (MAX_VARS + 1))
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_acc,
   input  logic [crls_pkg::ROW_W-1:0]  req_row,
   input  logic [crls_pkg::COL_W-1:0]  req_col,
   input  logic [crls_pkg::VAL_W-1:0]  req_value,
   input  crls_pkg::cmd_type           cmd,
   input  logic [WAW-1:0]              w_raddr,
   input  logic [WAW-1:0]              w_waddr,
   input  logic [CAW-1:0]              c_raddr,
   input  logic [CW-1:0]               det_idx,
   input  logic [IW-1:0]               sol_idx,
   input  logic [crls_pkg::SLOT_W-1:0] out_slot,
   output crls_pkg::stat_type          stat,
   output logic [crls_pkg::SLOT_W-1:0] slot_ff,
   output logic [crls_pkg::VAL_W-1:0]  value_ff,
   output logic [crls_pkg::STAT_W-1:0] status_ff,
   output logic                        final_ff
);
   import crls_pkg::*;

   localparam int NCOL   = MAX_VARS + 1;
   localparam int CDEPTH = MAX_VARS * NCOL;

   // entry store: data in RAM, one valid bit per entry so unloaded entries read zero
   logic [CDEPTH-1:0] cval_ff;
   logic              cval_rd_ff;
   logic [VAL_W-1:0]  c_rdata;
   logic              c_we;
   logic [CAW-1:0]    c_waddr;

   assign c_we    = req_acc && (int'(req_row) < MAX_VARS) && (int'(req_col) <= MAX_VARS);
   assign c_waddr = CAW'(int'(req_row) * NCOL + int'(req_col));

   crls_ram #(.WIDTH(VAL_W), .DEPTH(CDEPTH), .AW(CAW)) u_coef (
      .clock    (clock),
      .we       (c_we),
      .waddr    (c_waddr),
      .wdata    (req_value),
      .raddr    (c_raddr),
      .rdata_ff (c_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cval_ff <= '0;
      end else if (cmd.coef_clr) begin
         cval_ff <= '0;
      end else if (c_we) begin
         cval_ff[c_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cval_rd_ff <= cval_ff[c_raddr];
   end

   // work matrix
   logic [DET_W-1:0] w_rdata, w_wdata;
   logic [DET_W-1:0] a_ff, b_ff, ratio_ff, prod_ff;
   logic [DET_W-1:0] mul_res, div_res, prod_fin;
   logic             flip_ff;

   always_comb begin
      case (cmd.w_src)
         WSRC_COEF: w_wdata = cval_rd_ff ? {{16{c_rdata[VAL_W-1]}}, c_rdata, 16'b0} : '0;
         WSRC_A:    w_wdata = a_ff;
         WSRC_B:    w_wdata = b_ff;
         WSRC_SUB:  w_wdata = sat_sub64(a_ff, mul_res);
         default:   w_wdata = '0;
      endcase
   end

   crls_ram #(.WIDTH(DET_W), .DEPTH(MAX_VARS * MAX_VARS), .AW(WAW)) u_work (
      .clock    (clock),
      .we       (cmd.w_we),
      .waddr    (w_waddr),
      .wdata    (w_wdata),
      .raddr    (w_raddr),
      .rdata_ff (w_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.ld_a) begin
         a_ff <= w_rdata;
      end
      if (cmd.ld_b) begin
         b_ff <= w_rdata;
      end
      if (cmd.ratio_ld) begin
         ratio_ff <= div_res;
      end
      if (cmd.prod_init) begin
         prod_ff <= DET_ONE;
      end else if (cmd.prod_ld) begin
         prod_ff <= mul_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff <= 1'b0;
      end else if (cmd.flip_clr) begin
         flip_ff <= 1'b0;
      end else if (cmd.flip_tgl) begin
         flip_ff <= ~flip_ff;
      end
   end

   // 64x64 magnitude multiplier: four 32x32 partial products, one per cycle
   logic [DET_W-1:0]   ma_ff, mb_ff, pp_ff;
   logic               mneg_ff, mbusy_ff, pv_ff, plast_ff, mdone_ff;
   logic [1:0]         mcnt_ff, psh_ff;
   logic [2*DET_W-1:0] acc_ff, pp_shift;
   logic [DET_W-1:0]   mx, my;
   logic [31:0]        pa, pb;

   assign mx = cmd.mul_prod ? prod_ff : ratio_ff;
   assign my = cmd.mul_prod ? a_ff : b_ff;
   assign pa = mcnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign pb = mcnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];

   always_comb begin
      case (psh_ff)
         2'd0:    pp_shift = {64'b0, pp_ff};
         2'd1:    pp_shift = {32'b0, pp_ff, 32'b0};
         default: pp_shift = {pp_ff, 64'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         pv_ff    <= 1'b0;
         mdone_ff <= 1'b0;
      end else begin
         mdone_ff <= 1'b0;
         pv_ff    <= mbusy_ff;
         if (cmd.mul_start) begin
            ma_ff    <= mag64(mx);
            mb_ff    <= mag64(my);
            mneg_ff  <= mx[DET_W-1] ^ my[DET_W-1];
            acc_ff   <= '0;
            mcnt_ff  <= 2'd0;
            mbusy_ff <= 1'b1;
         end else if (mbusy_ff) begin
            pp_ff    <= {32'b0, pa} * {32'b0, pb};
            psh_ff   <= (mcnt_ff == 2'd0) ? 2'd0 : ((mcnt_ff == 2'd3) ? 2'd2 : 2'd1);
            plast_ff <= (mcnt_ff == 2'd3);
            mcnt_ff  <= mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) begin
               mbusy_ff <= 1'b0;
            end
         end
         if (pv_ff) begin
            acc_ff   <= acc_ff + pp_shift;
            mdone_ff <= plast_ff;
         end
      end
   end

   assign mul_res = from_mag64(acc_ff[95:32], mneg_ff, |acc_ff[127:96]);

   // determinants: D held alone, D_i in a small register file
   logic [DET_W-1:0] d0_ff;
   logic [DET_W-1:0] deti_ff [MAX_VARS];
   logic             any_nz_ff;

   assign prod_fin = flip_ff ? neg_sat64(prod_ff) : prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.det_wr) begin
         if (det_idx == '0) begin
            d0_ff     <= prod_fin;
            any_nz_ff <= 1'b0;
         end else begin
            deti_ff[IW'(det_idx - 1'b1)] <= prod_fin;
            any_nz_ff <= any_nz_ff | (prod_fin != '0);
         end
      end
   end

   logic div_done;

   crls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .sol_mode (cmd.div_sol),
      .num      (cmd.div_sol ? deti_ff[sol_idx] : a_ff),
      .den      (cmd.div_sol ? d0_ff : b_ff),
      .done_ff  (div_done),
      .result   (div_res)
   );

   // result word register
   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         if (cmd.out_status) begin
            slot_ff   <= '0;
            value_ff  <= '0;
            status_ff <= any_nz_ff ? STAT_NONE : STAT_INFINITE;
            final_ff  <= 1'b1;
         end else begin
            slot_ff   <= out_slot;
            value_ff  <= div_res[VAL_W-1:0];
            status_ff <= STAT_UNIQUE;
            final_ff  <= cmd.out_final;
         end
      end
   end

   assign stat.a_zero   = (a_ff == '0);
   assign stat.b_zero   = (b_ff == '0);
   assign stat.div_done = div_done;
   assign stat.mul_done = mdone_ff;
   assign stat.d0_zero  = (d0_ff == '0);
   assign stat.any_nz   = any_nz_ff;
endmodule

// File: hdl/crls_ctrl.sv
// Solve sequencer: loads each work matrix, runs the elimination, the diagonal
// product and the final divisions, and handles both handshakes. Depends on crls_pkg.
module crls_ctrl #(
   parameter int MAX_VARS = crls_pkg::MAX_VARS_DEF,
   parameter int CW       = $clog2(MAX_VARS + 1),
   parameter int IW       = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1,
   parameter int WAW      = (MAX_VARS * MAX_VARS > 1) ? $clog2(MAX_VARS * MAX_VARS) : 1,
   parameter int CAW      = $clog2(MAX_VARS * (MAX_VARS + 1))
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [crls_pkg::CFG_W-1:0]  var_count,
   input  logic                        req_acc,
   input  logic                        req_last,
   output logic                        req_ready,
   input  logic                        rsp_ready,
   output logic                        rsp_valid_ff,
   input  crls_pkg::stat_type          stat,
   output crls_pkg::cmd_type           cmd,
   output logic [WAW-1:0]              w_raddr,
   output logic [WAW-1:0]              w_waddr,
   output logic [CAW-1:0]              c_raddr,
   output logic [CW-1:0]               det_idx,
   output logic [IW-1:0]               sol_idx,
   output logic [crls_pkg::SLOT_W-1:0] out_slot
);
   import crls_pkg::*;

   localparam int NCOL = MAX_VARS + 1;

   typedef enum logic [4:0] {
      S_IDLE, S_LD_RD, S_LD_WR, S_EL_TOP, S_RA, S_RB, S_RB2, S_DEC,
      S_SW_RA, S_SW_RB, S_SW_W1, S_SW_W2, S_DIV,
      S_SB_RA, S_SB_RB, S_SB_M, S_SB_MW, S_SB_W, S_NEXTJ,
      S_PR_RD, S_PR_LD, S_PR_M, S_PR_W, S_DET_ST,
      S_OUT_TOP, S_SOL_W, S_OUT_WAIT, S_CLEAR
   } state_type;

   state_type   state_ff;
   logic [CW-1:0] r_ff, c_ff, i_ff, j_ff, k_ff, d_ff, o_ff;
   logic          last_ff;
   logic [CW-1:0] n, n_m1, swap_col, src_col, j_m1;

   function automatic logic [WAW-1:0] waddr(input logic [CW-1:0] r, input logic [CW-1:0] c);
      return WAW'(int'(r) * MAX_VARS + int'(c));
   endfunction

   always_comb begin
      if (var_count == '0) begin
         n = CW'(1);
      end else if (int'(var_count) > MAX_VARS) begin
         n = CW'(MAX_VARS);
      end else begin
         n = CW'(var_count);
      end
   end

   assign n_m1     = n - 1'b1;
   assign j_m1     = j_ff - 1'b1;
   // D uses the coefficients as they are; D_i takes column i from the constants
   assign swap_col = (d_ff == '0) ? n : (d_ff - 1'b1);
   assign src_col  = (c_ff == swap_col) ? n : c_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign det_idx   = d_ff;
   assign sol_idx   = IW'(o_ff);
   assign out_slot  = SLOT_W'(o_ff);
   assign c_raddr   = CAW'(int'(r_ff) * NCOL + int'(src_col));

   always_comb begin
      cmd     = '0;
      w_raddr = '0;
      w_waddr = '0;
      case (state_ff)
         S_LD_RD: begin
            cmd.prod_init = 1'b1;
            cmd.flip_clr  = 1'b1;
         end
         S_LD_WR: begin
            cmd.w_we  = 1'b1;
            cmd.w_src = WSRC_COEF;
            w_waddr   = waddr(r_ff, c_ff);
         end
         S_RA: w_raddr = waddr(j_ff, i_ff);
         S_RB: begin
            w_raddr  = waddr(j_m1, i_ff);
            cmd.ld_a = 1'b1;
         end
         S_RB2: cmd.ld_b = 1'b1;
         S_DEC: begin
            cmd.flip_tgl  = !stat.a_zero && stat.b_zero;
            cmd.div_start = !stat.a_zero && !stat.b_zero;
         end
         S_SW_RA: w_raddr = waddr(j_ff, k_ff);
         S_SW_RB: begin
            w_raddr  = waddr(j_m1, k_ff);
            cmd.ld_a = 1'b1;
         end
         S_SW_W1: begin
            cmd.ld_b  = 1'b1;
            cmd.w_we  = 1'b1;
            cmd.w_src = WSRC_A;
            w_waddr   = waddr(j_m1, k_ff);
         end
         S_SW_W2: begin
            cmd.w_we  = 1'b1;
            cmd.w_src = WSRC_B;
            w_waddr   = waddr(j_ff, k_ff);
         end
         S_DIV: cmd.ratio_ld = stat.div_done;
         S_SB_RA: w_raddr = waddr(j_m1, k_ff);
         S_SB_RB: begin
            w_raddr  = waddr(j_ff, k_ff);
            cmd.ld_b = 1'b1;
         end
         S_SB_M: begin
            cmd.ld_a      = 1'b1;
            cmd.mul_start = 1'b1;
         end
         S_SB_W: begin
            cmd.w_we  = 1'b1;
            // pivot column of the reduced row is forced to zero
            cmd.w_src = (k_ff == i_ff) ? WSRC_ZERO : WSRC_SUB;
            w_waddr   = waddr(j_ff, k_ff);
         end
         S_PR_RD: w_raddr = waddr(i_ff, i_ff);
         S_PR_LD: cmd.ld_a = 1'b1;
         S_PR_M: begin
            cmd.mul_start = 1'b1;
            cmd.mul_prod  = 1'b1;
         end
         S_PR_W: begin
            cmd.mul_prod = 1'b1;
            cmd.prod_ld  = stat.mul_done;
         end
         S_DET_ST: cmd.det_wr = 1'b1;
         S_OUT_TOP: begin
            cmd.out_ld     = stat.d0_zero;
            cmd.out_status = stat.d0_zero;
            cmd.div_start  = !stat.d0_zero;
            cmd.div_sol    = 1'b1;
         end
         S_SOL_W: begin
            cmd.div_sol   = 1'b1;
            cmd.out_ld    = stat.div_done;
            cmd.out_final = (o_ff == n_m1);
         end
         S_CLEAR: cmd.coef_clr = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
         r_ff         <= '0;
         c_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         d_ff         <= '0;
         o_ff         <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_acc && req_last) begin
                  d_ff     <= '0;
                  r_ff     <= '0;
                  c_ff     <= '0;
                  state_ff <= S_LD_RD;
               end
            end
            S_LD_RD: state_ff <= S_LD_WR;
            S_LD_WR: begin
               if (c_ff == n_m1) begin
                  c_ff <= '0;
                  if (r_ff == n_m1) begin
                     r_ff     <= '0;
                     i_ff     <= '0;
                     j_ff     <= n_m1;
                     state_ff <= S_EL_TOP;
                  end else begin
                     r_ff     <= r_ff + 1'b1;
                     state_ff <= S_LD_RD;
                  end
               end else begin
                  c_ff     <= c_ff + 1'b1;
                  state_ff <= S_LD_RD;
               end
            end
            S_EL_TOP: begin
               if (j_ff > i_ff) begin
                  state_ff <= S_RA;
               end else if (i_ff == n_m1) begin
                  i_ff     <= '0;
                  state_ff <= S_PR_RD;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  j_ff <= n_m1;
               end
            end
            S_RA:  state_ff <= S_RB;
            S_RB:  state_ff <= S_RB2;
            S_RB2: state_ff <= S_DEC;
            S_DEC: begin
               k_ff <= '0;
               if (stat.a_zero) begin
                  state_ff <= S_NEXTJ;
               end else if (stat.b_zero) begin
                  state_ff <= S_SW_RA;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_SW_RA: state_ff <= S_SW_RB;
            S_SW_RB: state_ff <= S_SW_W1;
            S_SW_W1: state_ff <= S_SW_W2;
            S_SW_W2: begin
               if (k_ff == n_m1) begin
                  state_ff <= S_NEXTJ;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_SW_RA;
               end
            end
            S_DIV: begin
               if (stat.div_done) begin
                  state_ff <= S_SB_RA;
               end
            end
            S_SB_RA: state_ff <= S_SB_RB;
            S_SB_RB: state_ff <= S_SB_M;
            S_SB_M:  state_ff <= S_SB_MW;
            S_SB_MW: begin
               if (stat.mul_done) begin
                  state_ff <= S_SB_W;
               end
            end
            S_SB_W: begin
               if (k_ff == n_m1) begin
                  state_ff <= S_NEXTJ;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_SB_RA;
               end
            end
            S_NEXTJ: begin
               j_ff     <= j_m1;
               state_ff <= S_EL_TOP;
            end
            S_PR_RD: state_ff <= S_PR_LD;
            S_PR_LD: state_ff <= S_PR_M;
            S_PR_M:  state_ff <= S_PR_W;
            S_PR_W: begin
               if (stat.mul_done) begin
                  if (i_ff == n_m1) begin
                     state_ff <= S_DET_ST;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_PR_RD;
                  end
               end
            end
            S_DET_ST: begin
               if (d_ff == n) begin
                  o_ff     <= '0;
                  state_ff <= S_OUT_TOP;
               end else begin
                  d_ff     <= d_ff + 1'b1;
                  r_ff     <= '0;
                  c_ff     <= '0;
                  state_ff <= S_LD_RD;
               end
            end
            S_OUT_TOP: begin
               if (stat.d0_zero) begin
                  rsp_valid_ff <= 1'b1;
                  last_ff      <= 1'b1;
                  state_ff     <= S_OUT_WAIT;
               end else begin
                  state_ff <= S_SOL_W;
               end
            end
            S_SOL_W: begin
               if (stat.div_done) begin
                  rsp_valid_ff <= 1'b1;
                  last_ff      <= (o_ff == n_m1);
                  state_ff     <= S_OUT_WAIT;
               end
            end
            S_OUT_WAIT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (last_ff) begin
                     state_ff <= S_CLEAR;
                  end else begin
                     o_ff     <= o_ff + 1'b1;
                     state_ff <= S_OUT_TOP;
                  end
               end
            end
            S_CLEAR: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: hdl/cramer_linear_solver.sv
// Top level of the Cramer's rule linear system solver: channels, register port,
// sequencer and datapath. Depends on crls_pkg, crls_if, crls_ctrl, crls_dp.
//
//   port     | dir | protocol      | word
//   req_bus  | in  | valid/ready   | row_index, col_index, entry_value, last_entry
//   rsp_bus  | out | valid/ready   | var_slot, solution_value, solve_status, final_result
//   p*       | in  | APB, pready=1 | var_count at byte address 0
//
// A non-last entry word is taken while the sequencer is idle. The word marked last
// starts the solve; no word is accepted until its last result word has been taken.
// A solve runs n+1 determinants, each a matrix load and up to n(n-1)/2 eliminations,
// each a row swap or a division and n multiply-subtract passes, then a diagonal
// product. Each solution word costs one division. A stalled result holds the
// sequencer. Reset is synchronous; the entry store is cleared by its valid bits at
// reset and after every solve.
module cramer_linear_solver #(
   parameter int MAX_VARS = crls_pkg::MAX_VARS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   crls_req_if.sink                    req_bus,
   crls_rsp_if.source                  rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [crls_pkg::CSR_AW-1:0] paddr,
   input  logic [crls_pkg::CSR_DW-1:0] pwdata,
   output logic [crls_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);
   import crls_pkg::*;

   localparam int CW  = $clog2(MAX_VARS + 1);
   localparam int IW  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int WAW = (MAX_VARS * MAX_VARS > 1) ? $clog2(MAX_VARS * MAX_VARS) : 1;
   localparam int CAW = $clog2(MAX_VARS * (MAX_VARS + 1));

   logic [CFG_W-1:0] var_count_ff;

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_VAR_COUNT) ? {{(CSR_DW-CFG_W){1'b0}}, var_count_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         var_count_ff <= VAR_COUNT_RST;
      end else if (psel && penable && pwrite && pready && (paddr == CSR_VAR_COUNT)) begin
         var_count_ff <= pwdata[CFG_W-1:0];
      end
   end

   logic              req_acc;
   logic              rsp_valid;
   cmd_type           cmd;
   stat_type          stat;
   logic [WAW-1:0]    w_raddr, w_waddr;
   logic [CAW-1:0]    c_raddr;
   logic [CW-1:0]     det_idx;
   logic [IW-1:0]     sol_idx;
   logic [SLOT_W-1:0] out_slot;

   assign req_acc       = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = rsp_valid;

   crls_ctrl #(.MAX_VARS(MAX_VARS), .CW(CW), .IW(IW), .WAW(WAW), .CAW(CAW)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .var_count    (var_count_ff),
      .req_acc      (req_acc),
      .req_last     (req_bus.last_entry),
      .req_ready    (req_bus.ready),
      .rsp_ready    (rsp_bus.ready),
      .rsp_valid_ff (rsp_valid),
      .stat         (stat),
      .cmd          (cmd),
      .w_raddr      (w_raddr),
      .w_waddr      (w_waddr),
      .c_raddr      (c_raddr),
      .det_idx      (det_idx),
      .sol_idx      (sol_idx),
      .out_slot     (out_slot)
   );

   crls_dp #(.MAX_VARS(MAX_VARS), .CW(CW), .IW(IW), .WAW(WAW), .CAW(CAW)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_acc   (req_acc),
      .req_row   (req_bus.row_index),
      .req_col   (req_bus.col_index),
      .req_value (req_bus.entry_value),
      .cmd       (cmd),
      .w_raddr   (w_raddr),
      .w_waddr   (w_waddr),
      .c_raddr   (c_raddr),
      .det_idx   (det_idx),
      .sol_idx   (sol_idx),
      .out_slot  (out_slot),
      .stat      (stat),
      .slot_ff   (rsp_bus.var_slot),
      .value_ff  (rsp_bus.solution_value),
      .status_ff (rsp_bus.solve_status),
      .final_ff  (rsp_bus.final_result)
   );
endmodule
